FILE: rtl/core/kei_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyframe eased interpolator.
// Depends on nothing; used by keyframe_eased_interpolator_core.
package kei_pkg;

  localparam int FRAC_BITS = 12;
  // Width of progress and eased values (covers overshoot of the back curves).
  localparam int EW  = FRAC_BITS + 6;
  localparam int DCW = $clog2(FRAC_BITS + 1);

  localparam longint Q1L = longint'(1) << FRAC_BITS;
  localparam logic signed [EW-1:0] Q_ONE  = EW'(Q1L);
  localparam logic signed [EW-1:0] Q_HALF = EW'(Q1L / 2);
  localparam logic signed [EW-1:0] BACK_S = EW'((longint'(170158) << FRAC_BITS) / 100000);
  localparam logic signed [EW-1:0] BNC_K  = EW'((Q1L * 121) / 16);
  localparam logic signed [EW-1:0] BNC_T1 = EW'((Q1L * 4) / 11);
  localparam logic signed [EW-1:0] BNC_T2 = EW'((Q1L * 8) / 11);
  localparam logic signed [EW-1:0] BNC_T3 = EW'((Q1L * 10) / 11);
  localparam logic signed [EW-1:0] BNC_O1 = EW'((Q1L * 6) / 11);
  localparam logic signed [EW-1:0] BNC_O2 = EW'((Q1L * 9) / 11);
  localparam logic signed [EW-1:0] BNC_O3 = EW'((Q1L * 21) / 22);
  localparam logic signed [EW-1:0] BNC_A1 = EW'((Q1L * 3) / 4);
  localparam logic signed [EW-1:0] BNC_A2 = EW'((Q1L * 15) / 16);
  localparam logic signed [EW-1:0] BNC_A3 = EW'((Q1L * 63) / 64);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [3:0] EASE_LINEAR    = 4'd0;
  localparam logic [3:0] EASE_IN        = 4'd1;
  localparam logic [3:0] EASE_QUAD_OUT  = 4'd2;
  localparam logic [3:0] EASE_INOUT     = 4'd3;
  localparam logic [3:0] EASE_CUBIC_IN  = 4'd4;
  localparam logic [3:0] EASE_CUBIC_OUT = 4'd5;
  localparam logic [3:0] EASE_CUBIC_IO  = 4'd6;
  localparam logic [3:0] EASE_BACK_IN   = 4'd7;
  localparam logic [3:0] EASE_BACK_OUT  = 4'd8;
  localparam logic [3:0] EASE_BOUNCE    = 4'd9;

  localparam logic REG_KEY_COUNT = 1'b0;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         key_index;
    logic signed [15:0] key_frame;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_rot;
    logic signed [31:0] key_scale;
    logic [3:0]         key_ease;
    logic signed [15:0] timer;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_rot;
    logic signed [31:0] out_scale;
  } out_t;

  typedef struct packed {
    logic signed [15:0] frame;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] rot;
    logic signed [31:0] scale;
    logic [3:0]         ease;
  } rec_t;

endpackage

FILE: rtl/core/kei_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kei_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_i,
  output logic [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/keyframe_eased_interpolator_core.sv
`timescale 1ns / 1ps
// Keyframe table with eased interpolation between neighboring keyframes.
// Depends on kei_pkg and kei_ram.
//
// The block keeps up to MAX_KEYS keyframes in one RAM. A load word writes one
// slot in the cycle it is accepted. An evaluate word reads the first and last
// keyframe to clamp the timer, then walks the table one entry per cycle to find
// the first segment that holds it, divides the offset by the segment span in a
// restoring divider (one quotient bit per cycle) into a Q.12 progress value,
// runs the easing curve through a single shared multiplier (up to three
// products), and lerps x, y, rotation and scale on the same multiplier, one
// value per cycle. The block takes no new word while one is in flight, but it
// accepts the next word while a finished result still waits on the output
// register. key_count is written over the APB port at address 0; the user must
// write it only while the block is idle, and the block itself does not enforce
// this. Counts above MAX_KEYS act as MAX_KEYS. Table slots hold nothing until
// loaded, so only loaded slots may be counted.
module keyframe_eased_interpolator_core #(
  parameter int MAX_KEYS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kei_pkg::in_t         in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kei_pkg::out_t        out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import kei_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int CW = NW + 1;
  localparam int MA = 34;
  localparam int RW = $bits(rec_t);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_F0   = 9'b000000010,
    S_FL   = 9'b000000100,
    S_SRCH = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_EASE = 9'b000100000,
    S_LERP = 9'b001000000,
    S_KEY  = 9'b010000000,
    S_PUSH = 9'b100000000
  } state_e;

  state_e                 state_q, state_d;
  logic [4:0]             key_count_q;
  logic signed [15:0]     timer_q, timer_d;
  logic [NW-1:0]          n_q, n_d;
  logic [AW-1:0]          i_q, i_d;
  rec_t                   a_q, a_d, b_q, b_d;
  logic [16:0]            span_q, span_d;
  logic [16:0]            rem_q, rem_d;
  logic [FRAC_BITS-1:0]   quo_q, quo_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic signed [EW-1:0]   t_q, t_d, m1_q, m1_d, m2_q, m2_d, e_q, e_d;
  logic [1:0]             step_q, step_d;
  out_t                   res_q, res_d, out_q;
  logic                   out_valid_q;

  // Table RAM.
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, raddr_d;
  logic [RW-1:0]          ram_rdata;
  rec_t                   rd;
  rec_t                   wrec;
  logic [8:0]             kidx_w, kc_w, n_w;

  assign kidx_w = 9'(in_data_i.key_index);
  assign ram_waddr = kidx_w[AW-1:0];
  assign wrec = '{frame: in_data_i.key_frame, x: in_data_i.key_x, y: in_data_i.key_y,
                  rot: in_data_i.key_rot, scale: in_data_i.key_scale,
                  ease: in_data_i.key_ease};
  assign rd = rec_t'(ram_rdata);

  kei_ram #(.WIDTH(RW), .DEPTH(MAX_KEYS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wrec),
    .raddr_i (raddr_d),
    .rdata_o (ram_rdata)
  );

  assign kc_w = 9'(key_count_q);
  assign n_w  = (kc_w > 9'(MAX_KEYS)) ? 9'(MAX_KEYS) : kc_w;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEY_COUNT) ? 32'(key_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_KEY_COUNT) begin
      key_count_q <= pwdata[4:0];
    end
  end

  // Shared multiplier; every product is shifted down by FRAC_BITS.
  logic signed [MA-1:0]    mul_a;
  logic signed [EW-1:0]    mul_b;
  logic signed [MA+EW-1:0] prod, sh;
  logic signed [EW-1:0]    sh_e;

  assign prod = mul_a * mul_b;
  assign sh   = prod >>> FRAC_BITS;
  assign sh_e = sh[EW-1:0];

  // Easing micro-sequence: operands and post-processing for the current step.
  logic signed [EW-1:0] ez_a, ez_b, ez_add, f_m1, f_2m2, f_bnc, a_bnc;
  logic                 ez_m2, ez_last, ez_direct;
  logic [1:0]           ez_shift;
  logic signed [EW-1:0] ez_e;

  assign f_m1  = t_q - Q_ONE;
  assign f_2m2 = (t_q <<< 1) - (Q_ONE <<< 1);

  always_comb begin
    if (t_q < BNC_T1) begin
      f_bnc = t_q;
      a_bnc = '0;
    end else if (t_q < BNC_T2) begin
      f_bnc = t_q - BNC_O1;
      a_bnc = BNC_A1;
    end else if (t_q < BNC_T3) begin
      f_bnc = t_q - BNC_O2;
      a_bnc = BNC_A2;
    end else begin
      f_bnc = t_q - BNC_O3;
      a_bnc = BNC_A3;
    end
  end

  always_comb begin
    ez_a      = t_q;
    ez_b      = t_q;
    ez_add    = '0;
    ez_m2     = 1'b0;
    ez_last   = 1'b1;
    ez_direct = 1'b0;
    ez_shift  = 2'd0;
    case (a_q.ease)
      EASE_IN: begin
      end
      EASE_QUAD_OUT: begin
        ez_b = (Q_ONE <<< 1) - t_q;
      end
      EASE_INOUT: begin
        if (t_q < Q_HALF) begin
          ez_shift = 2'd1;
        end else begin
          ez_a   = (Q_ONE <<< 2) - (t_q <<< 1);
          ez_add = -Q_ONE;
        end
      end
      EASE_CUBIC_IN: begin
        if (step_q == 2'd0) begin
          ez_last = 1'b0;
        end else begin
          ez_a = m1_q;
        end
      end
      EASE_CUBIC_OUT: begin
        ez_b   = f_m1;
        ez_add = Q_ONE;
        if (step_q == 2'd0) begin
          ez_a    = f_m1;
          ez_last = 1'b0;
        end else begin
          ez_a = m1_q;
        end
      end
      EASE_CUBIC_IO: begin
        if (t_q < Q_HALF) begin
          ez_shift = 2'd2;
          if (step_q == 2'd0) begin
            ez_last = 1'b0;
          end else begin
            ez_a = m1_q;
          end
        end else begin
          ez_b   = f_2m2;
          ez_add = Q_ONE;
          if (step_q == 2'd0) begin
            ez_a    = Q_HALF;
            ez_last = 1'b0;
          end else begin
            ez_a    = m1_q;
            ez_last = (step_q == 2'd2);
          end
        end
      end
      EASE_BACK_IN: begin
        if (step_q == 2'd0) begin
          ez_last = 1'b0;
        end else if (step_q == 2'd1) begin
          ez_a    = BACK_S + Q_ONE;
          ez_m2   = 1'b1;
          ez_last = 1'b0;
        end else begin
          ez_a = m1_q;
          ez_b = m2_q - BACK_S;
        end
      end
      EASE_BACK_OUT: begin
        ez_add = Q_ONE;
        if (step_q == 2'd0) begin
          ez_a    = f_m1;
          ez_b    = f_m1;
          ez_last = 1'b0;
        end else if (step_q == 2'd1) begin
          ez_a    = BACK_S + Q_ONE;
          ez_b    = f_m1;
          ez_m2   = 1'b1;
          ez_last = 1'b0;
        end else begin
          ez_a = m1_q;
          ez_b = m2_q + BACK_S;
        end
      end
      EASE_BOUNCE: begin
        ez_b   = f_bnc;
        ez_add = a_bnc;
        if (step_q == 2'd0) begin
          ez_a    = BNC_K;
          ez_last = 1'b0;
        end else begin
          ez_a = m1_q;
        end
      end
      default: begin
        ez_direct = 1'b1;
      end
    endcase
  end

  assign ez_e = (sh_e <<< ez_shift) + ez_add;

  // Lerp operands for the value picked by step_q.
  logic signed [31:0] la, lb;
  logic signed [32:0] ldiff;
  logic signed [31:0] lres;

  always_comb begin
    case (step_q)
      2'd0: begin
        la = a_q.x;
        lb = b_q.x;
      end
      2'd1: begin
        la = a_q.y;
        lb = b_q.y;
      end
      2'd2: begin
        la = a_q.rot;
        lb = b_q.rot;
      end
      default: begin
        la = a_q.scale;
        lb = b_q.scale;
      end
    endcase
  end

  assign ldiff = 33'(lb) - 33'(la);
  assign lres  = la + sh[31:0];

  always_comb begin
    if (state_q == S_LERP) begin
      mul_a = MA'(ldiff);
      mul_b = e_q;
    end else begin
      mul_a = MA'(ez_a);
      mul_b = ez_b;
    end
  end

  // Segment test and divider step.
  logic               in_seg;
  logic signed [16:0] off_s, span_s;
  logic [17:0]        rem_sh;
  logic [NW-1:0]      nm1;
  logic [AW-1:0]      ip1, ip2;

  assign in_seg = (timer_q >= a_q.frame) && (timer_q <= rd.frame);
  assign off_s  = 17'(timer_q) - 17'(a_q.frame);
  assign span_s = 17'(rd.frame) - 17'(a_q.frame);
  assign rem_sh = {rem_q, 1'b0};
  assign nm1    = n_q - NW'(1);
  assign ip1    = i_q + AW'(1);
  assign ip2    = i_q + AW'(2);

  function automatic out_t rec_out(rec_t r);
    rec_out = '{out_x: r.x, out_y: r.y, out_rot: r.rot, out_scale: r.scale};
  endfunction

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    timer_d = timer_q;
    n_d     = n_q;
    i_d     = i_q;
    a_d     = a_q;
    b_d     = b_q;
    span_d  = span_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dcnt_d  = dcnt_q;
    t_d     = t_q;
    m1_d    = m1_q;
    m2_d    = m2_q;
    e_d     = e_q;
    step_d  = step_q;
    res_d   = res_q;
    raddr_d = '0;
    ram_we  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == CMD_LOAD) begin
            ram_we = (kidx_w < 9'(MAX_KEYS));
          end else if (n_w == 9'd0) begin
            res_d   = '{out_x: '0, out_y: '0, out_rot: '0, out_scale: 32'(Q_ONE)};
            state_d = S_PUSH;
          end else begin
            timer_d = in_data_i.timer;
            n_d     = NW'(n_w);
            state_d = S_F0;
          end
        end
      end
      S_F0: begin
        a_d = rd;
        if (timer_q <= rd.frame) begin
          res_d   = rec_out(rd);
          state_d = S_PUSH;
        end else begin
          raddr_d = nm1[AW-1:0];
          state_d = S_FL;
        end
      end
      S_FL: begin
        if (timer_q >= rd.frame) begin
          res_d   = rec_out(rd);
          state_d = S_PUSH;
        end else begin
          i_d     = '0;
          raddr_d = AW'(1);
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (in_seg) begin
          b_d    = rd;
          step_d = '0;
          if (off_s == span_s) begin
            t_d     = Q_ONE;
            state_d = S_EASE;
          end else begin
            rem_d   = off_s;
            span_d  = span_s;
            quo_d   = '0;
            dcnt_d  = DCW'(FRAC_BITS);
            state_d = S_DIV;
          end
        end else if (CW'(i_q) + CW'(2) < CW'(n_q)) begin
          a_d     = rd;
          i_d     = ip1;
          raddr_d = ip2;
        end else begin
          // No segment holds the timer: the first keyframe is the answer.
          raddr_d = '0;
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        res_d   = rec_out(rd);
        state_d = S_PUSH;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, span_q}) begin
          rem_d = 17'(rem_sh - {1'b0, span_q});
          quo_d = {quo_q[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[16:0];
          quo_d = {quo_q[FRAC_BITS-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          t_d     = EW'(quo_d);
          state_d = S_EASE;
        end
      end
      S_EASE: begin
        if (t_q <= '0 || t_q >= Q_ONE || ez_direct || ez_last) begin
          if (t_q <= '0) begin
            e_d = '0;
          end else if (t_q >= Q_ONE) begin
            e_d = Q_ONE;
          end else if (ez_direct) begin
            e_d = t_q;
          end else begin
            e_d = ez_e;
          end
          step_d  = '0;
          state_d = S_LERP;
        end else begin
          if (ez_m2) begin
            m2_d = sh_e;
          end else begin
            m1_d = sh_e;
          end
          step_d = step_q + 2'd1;
        end
      end
      S_LERP: begin
        case (step_q)
          2'd0:    res_d.out_x     = lres;
          2'd1:    res_d.out_y     = lres;
          2'd2:    res_d.out_rot   = lres;
          default: res_d.out_scale = lres;
        endcase
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      dcnt_q      <= '0;
      i_q         <= '0;
      n_q         <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      dcnt_q  <= dcnt_d;
      i_q     <= i_d;
      n_q     <= n_d;
      if (state_q == S_PUSH && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    timer_q <= timer_d;
    a_q     <= a_d;
    b_q     <= b_d;
    span_q  <= span_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    t_q     <= t_d;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    e_q     <= e_d;
    res_q   <= res_d;
    if (state_q == S_PUSH && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dcnt_q != '0))
    else $error("divider running with an exhausted bit count");

  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (CW'(i_q) + CW'(2) <= CW'(n_q)))
    else $error("segment search ran past the key count");

  a_progress_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EASE) |-> (t_q >= '0 && t_q <= Q_ONE))
    else $error("progress outside zero to one");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result did not reach the output register");

endmodule
